[src/lidar_scan_polar_to_cartesian_top_defines.svh]
// Assertion macros for the lidar scan polar-to-cartesian converter.
`ifndef LIDAR_SCAN_POLAR_TO_CARTESIAN_TOP_DEFINES_SVH
`define LIDAR_SCAN_POLAR_TO_CARTESIAN_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define LSPC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lspc: same-cycle check failed");
`define LSPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lspc: next-cycle check failed");
`else
`define LSPC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LSPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[src/lspc_pkg.sv]
// Shared types and constants for the lidar scan polar-to-cartesian converter.
`timescale 1ns / 1ps

package lspc_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ANGLE_BITS_DEF   = 20;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_RANGE_LOWER = 3'd0;
   localparam logic [2:0] REG_RANGE_UPPER = 3'd1;
   localparam logic [2:0] REG_START_ANGLE = 3'd2;
   localparam logic [2:0] REG_ANGLE_STEP  = 3'd3;
   localparam logic [2:0] REG_SCALE       = 3'd4;

   localparam logic [23:0] RANGE_LOWER_RST = 24'd0;
   localparam logic [23:0] RANGE_UPPER_RST = 24'hFFFFFF;
   localparam logic [19:0] START_ANGLE_RST = 20'd0;
   localparam logic [19:0] ANGLE_STEP_RST  = 20'd0;
   localparam logic [15:0] SCALE_RST       = 16'd5120;

   localparam logic [24:0] RANGE_MARGIN = 25'd410;
   localparam logic [23:0] CORDIC_GAIN  = 24'd10188014;

   typedef struct packed {
      logic [23:0] range_lower;
      logic [23:0] range_upper;
      logic [19:0] start_angle;
      logic [19:0] angle_step;
      logic [15:0] scale;
      logic        start_wr;
      logic [19:0] start_raw;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_GAIN_LO,
      ST_GAIN_HI,
      ST_PRE,
      ST_ROTATE,
      ST_DONE
   } state_type;

   function automatic logic [29:0] atan_entry(input logic [4:0] idx);
      logic [29:0] v;
      unique case (idx)
         5'd0:    v = 30'd536870912;
         5'd1:    v = 30'd316933406;
         5'd2:    v = 30'd167458907;
         5'd3:    v = 30'd85004756;
         5'd4:    v = 30'd42667331;
         5'd5:    v = 30'd21354465;
         5'd6:    v = 30'd10679838;
         5'd7:    v = 30'd5340245;
         5'd8:    v = 30'd2670163;
         5'd9:    v = 30'd1335087;
         5'd10:   v = 30'd667544;
         5'd11:   v = 30'd333772;
         5'd12:   v = 30'd166886;
         5'd13:   v = 30'd83443;
         5'd14:   v = 30'd41722;
         5'd15:   v = 30'd20861;
         5'd16:   v = 30'd10430;
         5'd17:   v = 30'd5215;
         5'd18:   v = 30'd2608;
         5'd19:   v = 30'd1304;
         5'd20:   v = 30'd652;
         5'd21:   v = 30'd326;
         5'd22:   v = 30'd163;
         5'd23:   v = 30'd81;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

[src/lspc_csr.sv]
// Configuration register file with APB-style access.
`timescale 1ns / 1ps

module lspc_csr
   import lspc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [23:0] lower_ff, lower_in;
   logic [23:0] upper_ff, upper_in;
   logic [19:0] start_ff, start_in;
   logic [19:0] step_ff, step_in;
   logic [15:0] scale_ff, scale_in;
   logic        wr_en;
   logic [2:0]  idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = csr_paddr[4:2];

   always_comb begin
      lower_in = lower_ff;
      upper_in = upper_ff;
      start_in = start_ff;
      step_in  = step_ff;
      scale_in = scale_ff;
      if (wr_en) begin
         unique case (idx)
            REG_RANGE_LOWER: lower_in = csr_pwdata[23:0];
            REG_RANGE_UPPER: upper_in = csr_pwdata[23:0];
            REG_START_ANGLE: start_in = csr_pwdata[19:0];
            REG_ANGLE_STEP:  step_in  = csr_pwdata[19:0];
            REG_SCALE:       scale_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= RANGE_LOWER_RST;
         upper_ff <= RANGE_UPPER_RST;
         start_ff <= START_ANGLE_RST;
         step_ff  <= ANGLE_STEP_RST;
         scale_ff <= SCALE_RST;
      end else begin
         lower_ff <= lower_in;
         upper_ff <= upper_in;
         start_ff <= start_in;
         step_ff  <= step_in;
         scale_ff <= scale_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_RANGE_LOWER: csr_prdata = {8'd0, lower_ff};
         REG_RANGE_UPPER: csr_prdata = {8'd0, upper_ff};
         REG_START_ANGLE: csr_prdata = {12'd0, start_ff};
         REG_ANGLE_STEP:  csr_prdata = {12'd0, step_ff};
         REG_SCALE:       csr_prdata = {16'd0, scale_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.range_lower = lower_ff;
      cfg.range_upper = upper_ff;
      cfg.start_angle = start_ff;
      cfg.angle_step  = step_ff;
      cfg.scale       = scale_ff;
      cfg.start_wr    = wr_en && (idx == REG_START_ANGLE);
      cfg.start_raw   = csr_pwdata[19:0];
   end

endmodule

[src/lspc_core.sv]
// Sequencer with shared multiplier and iterative CORDIC rotator.
`timescale 1ns / 1ps

module lspc_core
   import lspc_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
   parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] range_sample
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [24:0] point_x, [49:25] point_y
   output logic        rsp_tuser,   // [0] kept
   output logic        rsp_tlast
);

   localparam int ITER_W = $clog2(CORDIC_STEPS);

   state_type state_ff, state_in;

   logic [ANGLE_BITS-1:0] beam_ff, beam_in;
   logic [ANGLE_BITS-1:0] angle_ff, angle_in;
   logic [23:0]           range_ff, range_in;
   logic                  last_ff, last_in;
   logic                  keep_ff, keep_in;
   logic                  flip_ff, flip_in;
   logic [39:0]           mul_ff, mul_in;
   logic [37:0]           acc_ff, acc_in;
   logic [13:0]           dhi_ff, dhi_in;
   logic signed [37:0]    x_ff, x_in;
   logic signed [37:0]    y_ff, y_in;
   logic signed [33:0]    z_ff, z_in;
   logic [ITER_W-1:0]     iter_ff, iter_in;

   logic                  out_valid_ff, out_valid_in;
   logic [24:0]           out_x_ff, out_x_in;
   logic [24:0]           out_y_ff, out_y_in;
   logic                  out_keep_ff, out_keep_in;
   logic                  out_last_ff, out_last_in;

   logic [23:0]           mul_a;
   logic [23:0]           mul_b;
   logic [47:0]           mul_p;
   logic [27:0]           d_val;
   logic [52:0]           gain_sum;
   logic [ANGLE_BITS+31:0] angle_wide;
   logic signed [33:0]    z_pre;
   logic signed [37:0]    dx;
   logic signed [37:0]    dy;
   logic signed [33:0]    ztab;
   logic signed [37:0]    x_fin;
   logic signed [37:0]    y_fin;
   logic                  accept;
   logic                  gate_lo;
   logic                  gate_hi;
   logic                  out_free;

   function automatic logic [ANGLE_BITS-1:0] to_angle(input logic [19:0] raw);
      logic [51:0] w;
      w = {raw, 32'd0};
      return w[51 -: ANGLE_BITS];
   endfunction

   function automatic logic [24:0] sat_round(input logic signed [37:0] v);
      logic signed [37:0] r;
      logic [24:0]        o;
      r = (v + 38'sd128) >>> 8;
      if (r > 38'sd16777215) begin
         o = 25'h0FFFFFF;
      end else if (r < -38'sd16777216) begin
         o = 25'h1000000;
      end else begin
         o = r[24:0];
      end
      return o;
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   assign gate_lo = req_tdata > cfg.range_lower;
   assign gate_hi = ({1'b0, req_tdata} + RANGE_MARGIN) < {1'b0, cfg.range_upper};

   assign mul_p      = mul_a * mul_b;
   assign d_val      = 28'((mul_ff + 40'd2048) >> 12);
   assign gain_sum   = 53'(acc_ff) + (53'(mul_ff[37:0]) << 14) + 53'd32768;
   assign angle_wide = {angle_ff, 32'd0};
   assign z_pre      = {{2{angle_wide[ANGLE_BITS+31]}}, angle_wide[ANGLE_BITS+31 -: 32]};
   assign dx         = y_ff >>> iter_ff;
   assign dy         = x_ff >>> iter_ff;
   assign ztab       = $signed({4'd0, atan_entry(5'(iter_ff))});
   assign x_fin      = flip_ff ? -x_ff : x_ff;
   assign y_fin      = flip_ff ? -y_ff : y_ff;

   always_comb begin
      unique case (state_ff)
         ST_SCALE: begin
            mul_a = range_ff;
            mul_b = {8'd0, cfg.scale};
         end
         ST_GAIN_LO: begin
            mul_a = {10'd0, d_val[13:0]};
            mul_b = CORDIC_GAIN;
         end
         ST_GAIN_HI: begin
            mul_a = {10'd0, dhi_ff};
            mul_b = CORDIC_GAIN;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      beam_in      = beam_ff;
      angle_in     = angle_ff;
      range_in     = range_ff;
      last_in      = last_ff;
      keep_in      = keep_ff;
      flip_in      = flip_ff;
      mul_in       = mul_ff;
      acc_in       = acc_ff;
      dhi_in       = dhi_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      iter_in      = iter_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_keep_in  = out_keep_ff;
      out_last_in  = out_last_ff;

      if (cfg.start_wr) begin
         beam_in = to_angle(cfg.start_raw);
      end else if (accept) begin
         beam_in = req_tlast ? to_angle(cfg.start_angle)
                             : beam_ff + to_angle(cfg.angle_step);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               range_in = req_tdata;
               last_in  = req_tlast;
               keep_in  = gate_lo && gate_hi;
               angle_in = beam_ff;
               state_in = (gate_lo && gate_hi) ? ST_SCALE : ST_DONE;
            end
         end
         ST_SCALE: begin
            mul_in   = mul_p[39:0];
            state_in = ST_GAIN_LO;
         end
         ST_GAIN_LO: begin
            dhi_in   = d_val[27:14];
            mul_in   = mul_p[39:0];
            state_in = ST_GAIN_HI;
         end
         ST_GAIN_HI: begin
            acc_in   = mul_ff[37:0];
            mul_in   = mul_p[39:0];
            state_in = ST_PRE;
         end
         ST_PRE: begin
            x_in    = $signed({1'b0, gain_sum[52:16]});
            y_in    = '0;
            iter_in = '0;
            if (z_pre >= 34'sd1073741824) begin
               z_in    = z_pre - 34'sd2147483648;
               flip_in = 1'b1;
            end else if (z_pre < -34'sd1073741824) begin
               z_in    = z_pre + 34'sd2147483648;
               flip_in = 1'b1;
            end else begin
               z_in    = z_pre;
               flip_in = 1'b0;
            end
            state_in = ST_ROTATE;
         end
         ST_ROTATE: begin
            if (!z_ff[33]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - ztab;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + ztab;
            end
            iter_in = iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_keep_in  = keep_ff;
               out_last_in  = last_ff;
               out_x_in     = keep_ff ? sat_round(x_fin) : '0;
               out_y_in     = keep_ff ? sat_round(y_fin) : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         beam_ff      <= to_angle(START_ANGLE_RST);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         beam_ff      <= beam_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff    <= angle_in;
      range_ff    <= range_in;
      last_ff     <= last_in;
      keep_ff     <= keep_in;
      flip_ff     <= flip_in;
      mul_ff      <= mul_in;
      acc_ff      <= acc_in;
      dhi_ff      <= dhi_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      iter_ff     <= iter_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_keep_ff <= out_keep_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_y_ff, out_x_ff};
   assign rsp_tuser  = out_keep_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

[src/lidar_scan_polar_to_cartesian_top.sv]
// A kept sample runs SCALE, GAIN_LO, GAIN_HI, PRE, ROTATE, then DONE, before it shows on rsp.
// A rejected sample goes from IDLE straight to DONE before it shows on rsp.
// A new sample is taken only in IDLE, so none is taken until the last one leaves DONE;
// it leaves DONE once the result register is free. The result register frees req while rsp stalls.
// Reset: synchronous, active high; clears control, restores register defaults, angle to 0.
`timescale 1ns / 1ps

`include "lidar_scan_polar_to_cartesian_top_defines.svh"

module lidar_scan_polar_to_cartesian_top
   import lspc_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
   parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // [23:0] range_sample
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [55:0]           rsp_tdata,   // [24:0] point_x, [49:25] point_y
   output logic                  rsp_tuser,   // [0] kept
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   lspc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lspc_core #(
      .CORDIC_STEPS (CORDIC_STEPS),
      .ANGLE_BITS   (ANGLE_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `LSPC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)
   `LSPC_ASSERT_IMPLY(a_reject_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == 56'd0)
   `LSPC_ASSERT_IMPLY(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[55:50] == 6'd0)

endmodule
